// ===== hdl/ldms_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and face decode for the led dice scanner
// no dependencies; imported by every module of the block
package ldms_pkg;

  // defaults for the top-level parameters
  localparam int NUM_DICE_DEF     = 3;
  localparam int PERIOD_TICKS_DEF = 100;

  // number of face fields carried by one load request
  localparam int FACE_FIELDS = 3;
  localparam int FACE_W      = 3;

  // brightness limits and reset value
  localparam logic [7:0] ON_MIN       = 8'd8;
  localparam logic [7:0] ON_MAX       = 8'd92;
  localparam logic [7:0] BRIGHT_RESET = 8'd50;

  // request kinds carried on tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  // scan phase of the current die
  typedef enum logic [1:0] {
    PH_LIGHT   = 2'd0,
    PH_DARK    = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  // one decoded input request
  typedef struct packed {
    opcode_t                          opcode;
    logic [FACE_FIELDS-1:0][FACE_W-1:0] face;
  } ldms_req_t;

  // one result item
  typedef struct packed {
    logic [2:0] die_enable;
    logic [3:0] pip_lit;
    logic [1:0] scan_die;
  } ldms_result_t;

  // pip groups for a face; blank and face seven give no pattern
  function automatic logic [3:0] pip_pattern(input logic [FACE_W-1:0] f);
    logic [3:0] p;
    case (f)
      3'd1:    p = 4'b0001;
      3'd2:    p = 4'b0100;
      3'd3:    p = 4'b0101;
      3'd4:    p = 4'b0110;
      3'd5:    p = 4'b0111;
      3'd6:    p = 4'b1110;
      default: p = 4'b0000;
    endcase
    return p;
  endfunction

  // on time from the brightness register, clamped to the allowed range
  function automatic logic [7:0] clamp_on(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (v > ON_MAX) v = ON_MAX;
    if (v < ON_MIN) v = ON_MIN;
    return v;
  endfunction

endpackage

// ===== hdl/ldms_core.sv =====
`timescale 1ns / 1ps
// scan state machine: face store, tick counter, phase sequencing, brightness
// depends on ldms_pkg
module ldms_core #(
  parameter int NUM_DICE     = ldms_pkg::NUM_DICE_DEF,
  parameter int PERIOD_TICKS = ldms_pkg::PERIOD_TICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 req_take,
  input  ldms_pkg::ldms_req_t  req,
  output ldms_pkg::ldms_result_t result_next
);
  import ldms_pkg::*;

  localparam int SCAN_W   = (NUM_DICE > 1) ? $clog2(NUM_DICE) : 1;
  localparam int LOADED   = (NUM_DICE < FACE_FIELDS) ? NUM_DICE : FACE_FIELDS;
  localparam int TICK_MAX = (PERIOD_TICKS > int'(ON_MAX)) ? PERIOD_TICKS : int'(ON_MAX);
  localparam int TICK_W   = $clog2(TICK_MAX + 1);
  localparam logic [TICK_W-1:0] PERIOD_T = TICK_W'(PERIOD_TICKS);
  localparam logic [SCAN_W-1:0] LAST_DIE = SCAN_W'(NUM_DICE - 1);

  logic [7:0]          brightness;
  logic [FACE_W-1:0]   face_store [LOADED];
  phase_t              phase, phase_next;
  logic [SCAN_W-1:0]   scan_index, scan_index_next;
  logic [TICK_W-1:0]   ticks_left, ticks_left_next;
  logic [NUM_DICE-1:0] enable_reg, enable_reg_next;
  logic [3:0]          pip_reg, pip_reg_next;

  logic [TICK_W-1:0]   on_ticks, off_ticks, ticks_dec;
  logic [FACE_W-1:0]   cur_face;
  logic [3:0]          cur_pattern;
  logic [7:0]          en_wide, scan_wide;

  // brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  // phase durations
  always_comb begin
    on_ticks  = TICK_W'(clamp_on(brightness));
    off_ticks = (PERIOD_T > on_ticks) ? PERIOD_T - on_ticks : TICK_W'(1);
  end

  // face of the die in the current slot; dice past the loaded ones stay blank
  always_comb begin
    cur_face = '0;
    for (int k = 0; k < LOADED; k++) begin
      if (scan_index == SCAN_W'(k)) cur_face = face_store[k];
    end
    cur_pattern = pip_pattern(cur_face);
  end

  // face store written on load requests
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LOADED; k++) face_store[k] <= '0;
    end else if (req_take && req.opcode == OP_LOAD) begin
      for (int k = 0; k < LOADED; k++) face_store[k] <= req.face[k];
    end
  end

  // next state for one tick request
  always_comb begin
    phase_next      = phase;
    scan_index_next = scan_index;
    ticks_left_next = ticks_left;
    enable_reg_next = enable_reg;
    pip_reg_next    = pip_reg;
    ticks_dec       = (ticks_left != '0) ? ticks_left - TICK_W'(1) : '0;
    if (req_take && req.opcode == OP_TICK) begin
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        unique case (phase)
          PH_DARK: begin
            pip_reg_next    = '0;
            phase_next      = PH_RELEASE;
            ticks_left_next = off_ticks;
          end
          PH_RELEASE: begin
            enable_reg_next = '0;
            scan_index_next = (scan_index == LAST_DIE) ? '0 : scan_index + SCAN_W'(1);
            phase_next      = PH_LIGHT;
            ticks_left_next = TICK_W'(1);
          end
          default: begin
            if (cur_pattern != '0) begin
              enable_reg_next = NUM_DICE'(1) << scan_index;
              pip_reg_next    = cur_pattern;
            end
            phase_next      = PH_DARK;
            ticks_left_next = on_ticks;
          end
        endcase
      end
    end
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LIGHT;
      scan_index <= '0;
      ticks_left <= TICK_W'(1);
      enable_reg <= '0;
      pip_reg    <= '0;
    end else begin
      phase      <= phase_next;
      scan_index <= scan_index_next;
      ticks_left <= ticks_left_next;
      enable_reg <= enable_reg_next;
      pip_reg    <= pip_reg_next;
    end
  end

  // result as held after this request, masked to the field widths
  always_comb begin
    en_wide                 = 8'(enable_reg_next);
    scan_wide               = 8'(scan_index_next);
    result_next.die_enable  = en_wide[2:0];
    result_next.pip_lit     = pip_reg_next;
    result_next.scan_die    = scan_wide[1:0];
  end

endmodule

// ===== hdl/ldms_out.sv =====
`timescale 1ns / 1ps
// result register with stream handshake toward the sink
// depends on ldms_pkg
module ldms_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_take,
  input  ldms_pkg::ldms_result_t result_next,
  output logic                   req_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata
);
  import ldms_pkg::*;

  ldms_result_t result;

  // a new request may enter whenever the held result leaves or none is held
  assign req_ready = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (req_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (req_take) result <= result_next;
  end

  assign m_tdata = {7'd0, result.scan_die, result.pip_lit, result.die_enable};

endmodule

// ===== hdl/led_dice_multiplex_scanner_top.sv =====
`timescale 1ns / 1ps
// Multiplexed LED dice scanner. Each request on the input stream is either a tick
// (tuser 0, one microsecond) or a load of three face values (tuser 1). Every request
// gives exactly one result: the die enable, pip groups and scan slot held after it.
// Each die is lit for the clamped brightness (8..92 ticks), darkened for the rest of
// the period, then the scan moves on and all dice stay dark for one tick. One request
// is taken every clock cycle unless a result held by a low m_tready stalls the input;
// its result sits in the output register in the next cycle. The state update is a single
// counter step and a small face table between the input and the result register. The
// next request enters in the same cycle that the held result is taken.
// depends on ldms_pkg, ldms_core, ldms_out
module led_dice_multiplex_scanner_top #(
  parameter int NUM_DICE     = ldms_pkg::NUM_DICE_DEF,
  parameter int PERIOD_TICKS = ldms_pkg::PERIOD_TICKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // brightness
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // first_face[2:0], second_face[5:3], third_face[8:6]
  input  logic [0:0]  s_tuser,     // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata      // die_enable[2:0], pip_lit[6:3], scan_die[8:7]
);
  import ldms_pkg::*;

  logic         req_take;
  ldms_req_t    req;
  ldms_result_t result_next;

  assign req_take = s_tvalid && s_tready;

  // unpack the request
  always_comb begin
    req.opcode = opcode_t'(s_tuser[0]);
    req.face[0] = s_tdata[2:0];
    req.face[1] = s_tdata[5:3];
    req.face[2] = s_tdata[8:6];
  end

  ldms_core #(
    .NUM_DICE     (NUM_DICE),
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_take    (req_take),
    .req         (req),
    .result_next (result_next)
  );

  ldms_out u_out (
    .clk         (clk),
    .rst         (rst),
    .req_take    (req_take),
    .result_next (result_next),
    .req_ready   (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // every accepted request leaves a result in the output register
  assert property (@(posedge clk) disable iff (rst) req_take |=> m_tvalid)
    else $error("accepted request produced no result");

  // at most one die is enabled at a time
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> $onehot0(m_tdata[2:0]))
    else $error("more than one die enabled");

  // pips are never lit without an enabled die
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6:3] != 4'd0) |-> (m_tdata[2:0] != 3'd0))
    else $error("pips lit with no die enabled");

endmodule

// ===== sim/led_dice_multiplex_scanner_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the led dice scanner: tick and load requests with random stalls
// on both streams, brightness rewritten between phases; depends on ldms_pkg and the top
module led_dice_multiplex_scanner_top_tb;
  import ldms_pkg::*;

  localparam int NUM_DICE     = NUM_DICE_DEF;
  localparam int PERIOD_TICKS = PERIOD_TICKS_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 141;
  localparam int PHASES       = 8;

  // tracks the scan state and holds the die drive expected for each request
  class led_scan_tracker;
    logic [FACE_W-1:0] faces [NUM_DICE];
    phase_t            phase;
    int unsigned       slot;
    logic [6:0]        ticks_left;
    logic [2:0]        enable;
    logic [3:0]        pips;
    logic [7:0]        brightness;
    ldms_result_t      drive_q [$];
    int unsigned       errors;

    function new();
      foreach (faces[i]) faces[i] = '0;
      phase      = PH_LIGHT;
      slot       = 0;
      ticks_left = 7'd1;
      enable     = '0;
      pips       = '0;
      brightness = BRIGHT_RESET;
      errors     = 0;
    endfunction

    function void set_brightness(logic [7:0] v);
      brightness = v;
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // one phase transition once the tick counter runs out
    function void next_phase();
      int unsigned idx;
      logic [7:0]  on;
      logic [3:0]  pat;
      bit          lit;
      idx = slot % NUM_DICE;
      on  = brightness;
      if (on > ON_MAX) on = ON_MAX;
      if (on < ON_MIN) on = ON_MIN;
      case (phase)
        PH_DARK: begin
          pips       = '0;
          phase      = PH_RELEASE;
          ticks_left = (PERIOD_TICKS > int'(on) + 1) ? 7'(PERIOD_TICKS - int'(on)) : 7'd1;
        end
        PH_RELEASE: begin
          enable     = '0;
          slot       = (idx + 1) % NUM_DICE;
          phase      = PH_LIGHT;
          ticks_left = 7'd1;
        end
        default: begin
          lit = 1'b1;
          case (faces[idx])
            3'd1:    pat = 4'b0001;
            3'd2:    pat = 4'b0100;
            3'd3:    pat = 4'b0101;
            3'd4:    pat = 4'b0110;
            3'd5:    pat = 4'b0111;
            3'd6:    pat = 4'b1110;
            default: begin
              pat = 4'b0000;
              lit = 1'b0;
            end
          endcase
          // blank and face seven leave the die dark but keep the timing
          if (lit) begin
            enable = 3'(1 << idx);
            pips   = pat;
          end
          phase      = PH_DARK;
          ticks_left = 7'(on);
        end
      endcase
    endfunction

    // accepted request: update the state and queue the drive it leaves behind
    function void take_request(opcode_t op, logic [2:0] f0, logic [2:0] f1, logic [2:0] f2);
      ldms_result_t r;
      if (op == OP_LOAD) begin
        faces[0] = f0;
        if (NUM_DICE > 1) faces[1] = f1;
        if (NUM_DICE > 2) faces[2] = f2;
      end else begin
        if (ticks_left > 0) ticks_left--;
        if (ticks_left == 0) next_phase();
      end
      r.die_enable = enable;
      r.pip_lit    = pips;
      r.scan_die   = 2'(slot);
      drive_q.push_back(r);
    endfunction

    // accepted result: compare against the oldest queued drive
    function void compare_drive(logic [15:0] d);
      ldms_result_t want;
      ldms_result_t got;
      got.die_enable = d[2:0];
      got.pip_lit    = d[6:3];
      got.scan_die   = d[8:7];
      if (drive_q.size() == 0) begin
        errors++;
        $error("result 0x%h with no request outstanding", d);
        return;
      end
      want = drive_q.pop_front();
      if (got.die_enable != want.die_enable) begin
        errors++;
        $error("die_enable: expected %0d, got %0d", want.die_enable, got.die_enable);
      end
      if (got.pip_lit != want.pip_lit) begin
        errors++;
        $error("pip_lit: expected %0d, got %0d", want.pip_lit, got.pip_lit);
      end
      if (got.scan_die != want.scan_die) begin
        errors++;
        $error("scan_die: expected %0d, got %0d", want.scan_die, got.scan_die);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // first_face[2:0], second_face[5:3], third_face[8:6]
  logic [0:0]  s_tuser;   // opcode[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // die_enable[2:0], pip_lit[6:3], scan_die[8:7]

  led_scan_tracker tracker;
  bit              tx_gaps;
  bit              rx_gaps;
  int unsigned     quiet_cycles;

  led_dice_multiplex_scanner_top #(
    .NUM_DICE     (NUM_DICE),
    .PERIOD_TICKS (PERIOD_TICKS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request on the input stream, with an occasional idle burst ahead of it
  task automatic drive_request(input opcode_t op, input logic [2:0] f0, input logic [2:0] f1,
                               input logic [2:0] f2);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, f2, f1, f0};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // ticks carry random face bits that the block must ignore
  task automatic send_tick();
    drive_request(OP_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)));
  endtask

  task automatic send_load(input logic [2:0] f0, input logic [2:0] f1, input logic [2:0] f2);
    drive_request(OP_LOAD, f0, f1, f2);
  endtask

  // mostly ticks so the scan keeps moving, loads now and then
  task automatic send_random();
    if ($urandom_range(0, 99) < 88) send_tick();
    else send_load(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
  endtask

  // brightness change only once every result is back
  task automatic write_brightness(input logic [7:0] v);
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tracker.set_brightness(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side with random stall bursts
  initial begin : rx_side
    int unsigned hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      // no leftover stall once idling is switched off
      if (!rx_gaps) hold = 0;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // handshake monitor and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready)
        tracker.take_request(opcode_t'(s_tuser[0]), s_tdata[2:0], s_tdata[5:3], s_tdata[8:6]);
      if (m_tvalid && m_tready) tracker.compare_drive(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL led_dice_multiplex_scanner_top");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [7:0] levels [PHASES-1];
    tracker   = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;
    // below, at and above the clamp limits, then one random level
    levels    = '{8'd0, 8'd255, 8'd8, 8'd92, 8'd7, 8'd93, 8'd0};
    levels[PHASES-2] = 8'($urandom_range(0, 255));
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: blank die lit, face seven, every face, loads during light and dark
    send_load(3'd0, 3'd0, 3'd0);
    send_tick();
    send_load(3'd7, 3'd7, 3'd7);
    send_load(3'd6, 3'd5, 3'd4);
    send_tick();
    send_load(3'd1, 3'd2, 3'd3);
    repeat (3) send_tick();
    send_load(3'd7, 3'd0, 3'd6);
    send_load(3'd5, 3'd3, 3'd1);
    send_load(3'd2, 3'd4, 3'd6);
    repeat (4) send_tick();
    send_load(3'd0, 3'd7, 3'd0);
    send_load(3'd6, 3'd6, 3'd6);

    // random phases, each at its own brightness; the last one runs without idling
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_brightness(levels[p-1]);
      tx_gaps = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_gaps = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_random();
    end

    // drain and report
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.errors == 0) $display("PASS led_dice_multiplex_scanner_top");
    else $display("FAIL led_dice_multiplex_scanner_top");
    $finish;
  end

endmodule
